// File: hw/rtl/attentional_evidence_race_step_macros.svh
// Assertion macros shared by the evidence race checker.
`ifndef ATTENTIONAL_EVIDENCE_RACE_STEP_MACROS_SVH
`define ATTENTIONAL_EVIDENCE_RACE_STEP_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low
`define AERS_ASSERT_IMPLIES(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("evidence race check failed");

// Next-cycle implication, sampled on clk, off while rst_n is low
`define AERS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("evidence race check failed");

`endif

// File: hw/rtl/aers_pkg.sv
// Types and constants for the attentional evidence race block.
package aers_pkg;

  localparam int VAL_W     = 32;
  localparam int FAC_W     = 17;
  localparam int EV_W      = 40;
  localparam int MS_W      = 16;
  localparam int RESP_W    = 17;
  localparam int CFG_IDX_W = 3;
  localparam int FIELD_ITEMS = 4;

  localparam logic [FAC_W-1:0] ONE_Q16 = 17'h10000;

  localparam logic signed [EV_W-1:0] EV_MAX = {1'b0, {(EV_W-1){1'b1}}};
  localparam logic signed [EV_W-1:0] EV_MIN = {1'b1, {(EV_W-1){1'b0}}};

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_A      = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_B      = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_C      = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_ITEM_D      = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAZE        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSEEN_DRFT = 3'd5;
  localparam logic [CFG_IDX_W-1:0] CFG_UNSEEN_NSE  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] CFG_MAX_DUR     = 3'd7;

  typedef logic signed [VAL_W-1:0] q16_t;
  typedef logic signed [EV_W-1:0]  ev_t;

  typedef struct packed {
    logic       new_trial;
    logic [1:0] fix_item;
    logic       fixation_ends;
    q16_t       noise_a;
    q16_t       noise_b;
    q16_t       noise_c;
    q16_t       noise_d;
  } aers_in_t;

  typedef struct packed {
    logic [1:0]        leader;
    logic              decided;
    logic              trial_done;
    logic [RESP_W-1:0] response_ms;
  } aers_out_t;

  // Per-lane step controls from the sequencer
  typedef struct packed {
    logic clr;
    logic mul1;
    logic mul2;
    logic acc;
    logic fixated;
    logic seen;
  } aers_lane_ctl_t;

endpackage

// File: hw/rtl/aers_lane.sv
// One evidence lane: scaled drift and noise, saturating accumulation.
module aers_lane (
  input  logic                         clk,
  input  logic                         rst_n,
  input  aers_pkg::aers_lane_ctl_t     ctl,
  input  aers_pkg::q16_t               value,
  input  aers_pkg::q16_t               noise,
  input  logic [aers_pkg::FAC_W-1:0]   gaze_discount,
  input  logic [aers_pkg::FAC_W-1:0]   unseen_drift_scale,
  input  logic [aers_pkg::FAC_W-1:0]   unseen_noise_scale,
  output aers_pkg::ev_t                evidence
);
  import aers_pkg::*;

  localparam int P1_W  = VAL_W + FAC_W + 1;
  localparam int D1_W  = P1_W - 16;
  localparam int P2_W  = D1_W + FAC_W + 1;
  localparam int D2_W  = P2_W - 16;
  localparam int SUM_W = EV_W + 2;

  logic [FAC_W-1:0]        g_fac;
  logic [FAC_W-1:0]        ud_fac;
  logic [FAC_W-1:0]        un_fac;
  logic signed [P1_W-1:0]  drift_prod;
  logic signed [P1_W-1:0]  noise_prod;
  logic signed [D1_W-1:0]  drift1_r;
  logic signed [D1_W-1:0]  noise1_r;
  logic signed [P2_W-1:0]  drift_prod2;
  logic signed [D2_W-1:0]  drift2_r;
  logic signed [SUM_W-1:0] sum;
  ev_t                     ev_r;
  ev_t                     ev_nxt;

  // Pick factors: 1.0 for a fixated or seen item
  assign g_fac  = ctl.fixated ? ONE_Q16 : gaze_discount;
  assign ud_fac = ctl.seen ? ONE_Q16 : unseen_drift_scale;
  assign un_fac = ctl.seen ? ONE_Q16 : unseen_noise_scale;

  // First products; upper bits give the floor of the Q16 shift
  assign drift_prod = value * $signed({1'b0, g_fac});
  assign noise_prod = noise * $signed({1'b0, un_fac});

  always_ff @(posedge clk) begin
    if (ctl.mul1) begin
      drift1_r <= drift_prod[P1_W-1:16];
      noise1_r <= noise_prod[P1_W-1:16];
    end
  end

  // Second drift product by the unseen scale
  assign drift_prod2 = drift1_r * $signed({1'b0, ud_fac});

  always_ff @(posedge clk) begin
    if (ctl.mul2) begin
      drift2_r <= drift_prod2[P2_W-1:16];
    end
  end

  // Accumulate and saturate to the evidence range
  assign sum = SUM_W'(ev_r) + SUM_W'(drift2_r) + SUM_W'(noise1_r);

  always_comb begin
    ev_nxt = ev_r;
    if (ctl.clr) begin
      ev_nxt = '0;
    end else if (ctl.acc) begin
      if (sum > SUM_W'(EV_MAX)) begin
        ev_nxt = EV_MAX;
      end else if (sum < SUM_W'(EV_MIN)) begin
        ev_nxt = EV_MIN;
      end else begin
        ev_nxt = sum[EV_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ev_r <= '0;
    end else begin
      ev_r <= ev_nxt;
    end
  end

  assign evidence = ev_r;

endmodule

// File: hw/rtl/aers_merge.sv
// Merge across lanes: leader by lowest index of the maximum, then the decision.
module aers_merge #(
  parameter int NUM_ITEMS = 4,
  localparam int IDX_W = $clog2(NUM_ITEMS)
) (
  input  logic             clk,
  input  logic             lead_en,
  input  aers_pkg::ev_t    evidence [NUM_ITEMS],
  output logic [IDX_W-1:0] leader,
  output logic             decided
);
  import aers_pkg::*;

  localparam logic signed [EV_W:0] ONE_EV = (EV_W+1)'(ONE_Q16);

  logic [NUM_ITEMS-1:0] wins;
  logic [IDX_W-1:0]     lead_idx;
  logic [IDX_W-1:0]     leader_r;
  ev_t                  lead_ev;
  logic signed [EV_W:0] gap [NUM_ITEMS];

  // Item i wins if it beats every lower index and ties or beats every higher
  always_comb begin
    for (int i = 0; i < NUM_ITEMS; i++) begin
      wins[i] = 1'b1;
      for (int j = 0; j < NUM_ITEMS; j++) begin
        if ((j < i) && !(evidence[i] > evidence[j])) begin
          wins[i] = 1'b0;
        end
        if ((j > i) && (evidence[j] > evidence[i])) begin
          wins[i] = 1'b0;
        end
      end
    end
  end

  // Encode the single winner
  always_comb begin
    lead_idx = '0;
    for (int i = 0; i < NUM_ITEMS; i++) begin
      if (wins[i]) begin
        lead_idx = lead_idx | IDX_W'(i);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (lead_en) begin
      leader_r <= lead_idx;
    end
  end

  // Decided when the leader leads every other item by at least 1.0
  assign lead_ev = evidence[leader_r];

  always_comb begin
    decided = 1'b1;
    for (int j = 0; j < NUM_ITEMS; j++) begin
      gap[j] = (EV_W+1)'(lead_ev) - (EV_W+1)'(evidence[j]);
      if ((IDX_W'(j) != leader_r) && (gap[j] < ONE_EV)) begin
        decided = 1'b0;
      end
    end
  end

  assign leader = leader_r;

endmodule

// File: hw/rtl/attentional_evidence_race_step.sv
// Top level of the attentional evidence race: one simulation tick per input transfer.
//
// Input channel (in_valid / in_stall / in_data) carries one tick: trial start,
// fixated item, fixation end and one noise sample per item. Result channel
// (out_valid / out_stall / out_data) returns one result per tick: leader,
// decided, trial_done and response_ms. The cfg_ channel writes the item values,
// the gaze and unseen scales and the maximum duration; cfg_ready is always high
// and writes belong between ticks, while the block is idle.
// A tick in a trial runs from its input transfer to out_valid through two
// multiply stages in every lane (MUL1, MUL2), then the accumulate (ACC), leader
// (LEAD) and decision (OUT) steps. A new tick is taken only in idle, once the last
// one is through; in_stall is high while the sequencer works on a tick.
// Idle ticks outside a trial skip the lanes: a repeat of the last outcome passes
// through the leader and decision steps, a tick before any trial through the
// decision step alone, and each returns to idle before the next transfer.
// The result sits in an output register; the next tick may be taken while it
// waits. If out_stall holds the register, the sequencer waits in its final
// step with the new result until the register frees up.
// Reset clears evidence, seen marks, elapsed time and trial state, and loads
// the configuration defaults (unit scales, maximum duration 65535 ms).
module attentional_evidence_race_step #(
  parameter int NUM_ITEMS       = 4,
  parameter int TICK_MS         = 1,
  parameter int NON_DECISION_MS = 0
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  aers_pkg::aers_in_t                in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output aers_pkg::aers_out_t               out_data,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [aers_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [aers_pkg::VAL_W-1:0]        cfg_data
);
  import aers_pkg::*;

  localparam int IDX_W = $clog2(NUM_ITEMS);

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_MUL1 = 3'd1;
  localparam logic [2:0] ST_MUL2 = 3'd2;
  localparam logic [2:0] ST_ACC  = 3'd3;
  localparam logic [2:0] ST_LEAD = 3'd4;
  localparam logic [2:0] ST_OUT  = 3'd5;

  // Configuration registers
  q16_t             item_value_r [FIELD_ITEMS];
  logic [FAC_W-1:0] gaze_r;
  logic [FAC_W-1:0] ud_scale_r;
  logic [FAC_W-1:0] un_scale_r;
  logic [MS_W-1:0]  max_dur_r;

  // Sequencer and trial state
  logic [2:0]           state_r;
  logic [2:0]           state_nxt;
  aers_in_t             in_r;
  logic [NUM_ITEMS-1:0] seen_r;
  logic [NUM_ITEMS-1:0] seen_nxt;
  logic [MS_W-1:0]      elapsed_r;
  logic [MS_W-1:0]      elapsed_nxt;
  logic [MS_W-1:0]      elapsed_base;
  logic [MS_W:0]        elapsed_sum;
  logic                 active_r;
  logic                 active_nxt;
  logic                 zero_r;
  logic                 zero_nxt;
  logic                 out_valid_r;
  logic                 out_valid_nxt;
  aers_out_t            out_r;
  aers_out_t            res;

  logic                 in_xfer;
  logic                 out_xfer;
  logic                 out_load;
  logic                 act;
  logic                 done;
  logic [RESP_W-1:0]    resp_full;

  q16_t                 noise_f [FIELD_ITEMS];
  ev_t                  evidence [NUM_ITEMS];
  aers_lane_ctl_t       lane_ctl [NUM_ITEMS];
  logic [IDX_W-1:0]     lead_idx;
  logic                 decided;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state_r != ST_IDLE);
  assign in_xfer   = in_valid && !in_stall;
  assign out_xfer  = out_valid_r && !out_stall;
  assign out_load  = (state_r == ST_OUT) && (!out_valid_r || !out_stall);

  // Configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < FIELD_ITEMS; i++) begin
        item_value_r[i] <= '0;
      end
      gaze_r     <= ONE_Q16;
      ud_scale_r <= ONE_Q16;
      un_scale_r <= ONE_Q16;
      max_dur_r  <= '1;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_ITEM_A:      item_value_r[0] <= cfg_data;
        CFG_ITEM_B:      item_value_r[1] <= cfg_data;
        CFG_ITEM_C:      item_value_r[2] <= cfg_data;
        CFG_ITEM_D:      item_value_r[3] <= cfg_data;
        CFG_GAZE:        gaze_r          <= cfg_data[FAC_W-1:0];
        CFG_UNSEEN_DRFT: ud_scale_r      <= cfg_data[FAC_W-1:0];
        CFG_UNSEEN_NSE:  un_scale_r      <= cfg_data[FAC_W-1:0];
        CFG_MAX_DUR:     max_dur_r       <= cfg_data[MS_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // Trial bookkeeping at the input transfer
  assign act          = in_data.new_trial || active_r;
  assign elapsed_base = in_data.new_trial ? '0 : elapsed_r;
  assign elapsed_sum  = (MS_W+1)'(elapsed_base) + (MS_W+1)'(TICK_MS);

  always_comb begin
    seen_nxt    = seen_r;
    elapsed_nxt = elapsed_r;
    active_nxt  = active_r;
    zero_nxt    = zero_r;
    if (in_xfer) begin
      if (in_data.new_trial) begin
        seen_nxt    = '0;
        elapsed_nxt = '0;
      end
      if (act) begin
        for (int i = 0; i < NUM_ITEMS; i++) begin
          if (int'(in_data.fix_item) == i) begin
            seen_nxt[i] = 1'b1;
          end
        end
        elapsed_nxt = elapsed_sum[MS_W] ? '1 : elapsed_sum[MS_W-1:0];
      end
      active_nxt = act;
      zero_nxt   = !act && (elapsed_r == '0);
    end else if (out_load && done) begin
      active_nxt = 1'b0;
    end
  end

  // Step through the tick
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_xfer) begin
          if (act) begin
            state_nxt = ST_MUL1;
          end else if (elapsed_r == '0) begin
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_LEAD;
          end
        end
      end
      ST_MUL1: state_nxt = ST_MUL2;
      ST_MUL2: state_nxt = ST_ACC;
      ST_ACC:  state_nxt = ST_LEAD;
      ST_LEAD: state_nxt = ST_OUT;
      ST_OUT: begin
        if (out_load) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      seen_r    <= '0;
      elapsed_r <= '0;
      active_r  <= 1'b0;
      zero_r    <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      seen_r    <= seen_nxt;
      elapsed_r <= elapsed_nxt;
      active_r  <= active_nxt;
      zero_r    <= zero_nxt;
    end
  end

  // Hold the tick payload for the lanes
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      in_r <= in_data;
    end
  end

  assign noise_f[0] = in_r.noise_a;
  assign noise_f[1] = in_r.noise_b;
  assign noise_f[2] = in_r.noise_c;
  assign noise_f[3] = in_r.noise_d;

  // Lanes, one per item; items past the fields race with zero value and noise
  for (genvar i = 0; i < NUM_ITEMS; i++) begin : g_lane
    q16_t lane_val;
    q16_t lane_noise;

    if (i < FIELD_ITEMS) begin : g_fed
      assign lane_val   = item_value_r[i];
      assign lane_noise = noise_f[i];
    end else begin : g_zero
      assign lane_val   = '0;
      assign lane_noise = '0;
    end

    assign lane_ctl[i].clr     = in_xfer && in_data.new_trial;
    assign lane_ctl[i].mul1    = (state_r == ST_MUL1);
    assign lane_ctl[i].mul2    = (state_r == ST_MUL2);
    assign lane_ctl[i].acc     = (state_r == ST_ACC);
    assign lane_ctl[i].fixated = (int'(in_r.fix_item) == i);
    assign lane_ctl[i].seen    = seen_r[i];

    aers_lane u_lane (
      .clk                (clk),
      .rst_n              (rst_n),
      .ctl                (lane_ctl[i]),
      .value              (lane_val),
      .noise              (lane_noise),
      .gaze_discount      (gaze_r),
      .unseen_drift_scale (ud_scale_r),
      .unseen_noise_scale (un_scale_r),
      .evidence           (evidence[i])
    );
  end

  aers_merge #(
    .NUM_ITEMS (NUM_ITEMS)
  ) u_merge (
    .clk      (clk),
    .lead_en  (state_r == ST_LEAD),
    .evidence (evidence),
    .leader   (lead_idx),
    .decided  (decided)
  );

  // Form the result
  assign done = !active_r || decided ||
                (in_r.fixation_ends && (elapsed_r >= max_dur_r));
  assign resp_full = RESP_W'(decided ? elapsed_r : max_dur_r) + RESP_W'(NON_DECISION_MS);

  always_comb begin
    res = '0;
    if (!zero_r) begin
      res.leader      = 2'(lead_idx);
      res.decided     = decided;
      res.trial_done  = done;
      res.response_ms = done ? resp_full : '0;
    end
  end

  // Output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (out_xfer) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

// File: hw/rtl/aers_checker.sv
// Port-level checks for the evidence race top level, bound to it.
`include "attentional_evidence_race_step_macros.svh"

module aers_checker (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input aers_pkg::aers_out_t  out_data
);

  // A tick keeps the block busy after its transfer
  `AERS_ASSERT_NEXT(a_busy_after_xfer, rst_n && in_valid && !in_stall, in_stall)

  // An open trial reports no response time
  `AERS_ASSERT_IMPLIES(a_resp_zero_open, out_valid && !out_data.trial_done, out_data.response_ms == '0)

  // A decision always ends the trial
  `AERS_ASSERT_IMPLIES(a_decided_done, out_valid && out_data.decided, out_data.trial_done)

  // A stalled result holds
  `AERS_ASSERT_NEXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

endmodule

bind attentional_evidence_race_step aers_checker u_aers_checker (.*);
